### rtl/core/kehr_pkg.sv
`timescale 1ns / 1ps

package kehr_pkg;

  // Default sizes
  localparam int NumSlotsDefault  = 14;
  localparam int TableSizeDefault = 128;

  // Fixed report layout
  localparam int MapEntries = 128;
  localparam int ReportLen  = 16;
  localparam int SlotBytes  = 13;
  localparam int HeadBytes  = 3;

  // Depth of the queue between front and back
  localparam int QueueDepth = 2;

  // Field codes
  localparam logic [15:0] EvTypeKey = 16'd1;
  localparam logic [1:0]  KeyRelease = 2'd0;
  localparam logic [1:0]  KeyPress   = 2'd1;
  localparam logic [1:0]  KeyRepeat  = 2'd2;

  // Configuration register indexes
  localparam logic RegReportId = 1'b0;
  localparam logic RegModifier = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] ReportIdReset = 8'h01;
  localparam logic [7:0] ModifierReset = 8'h00;

  // Key code to HID usage
  localparam logic [7:0] CodeToUsage [MapEntries] = '{
    8'h00, 8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25,
    8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A, 8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15,
    8'h17, 8'h1C, 8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h28, 8'hE0,
    8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33,
    8'h34, 8'h35, 8'hE1, 8'h32, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11,
    8'h10, 8'h36, 8'h37, 8'h38, 8'hE5, 8'h55, 8'hE2, 8'h2C, 8'h39, 8'h3A,
    8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h53,
    8'h47, 8'h5F, 8'h60, 8'h61, 8'h56, 8'h5C, 8'h5D, 8'h5E, 8'h57, 8'h59,
    8'h5A, 8'h5B, 8'h62, 8'h63, 8'h00, 8'h00, 8'h00, 8'h44, 8'h45, 8'h87,
    8'h6A, 8'h00, 8'h8A, 8'h88, 8'h8B, 8'h00, 8'h58, 8'hE4, 8'h54, 8'h46,
    8'hE6, 8'h00, 8'h4A, 8'h52, 8'h4B, 8'h5C, 8'h4F, 8'h4D, 8'h51, 8'h4E,
    8'h49, 8'h4C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h89, 8'hE3, 8'hE7, 8'h65
  };

  // Command handed from front to back
  typedef struct packed {
    logic [7:0] usage;
    logic       press;
  } cmd_t;

endpackage

### rtl/core/kehr_front.sv
`timescale 1ns / 1ps

module kehr_front #(
  parameter int TABLE_SIZE = kehr_pkg::TableSizeDefault
) (
  input  logic              in_valid_i,
  input  logic              q_full_i,
  input  logic [15:0]       event_type_i,
  input  logic [9:0]        key_code_i,
  input  logic [1:0]        key_value_i,
  output logic              in_stall_o,
  output logic              push_o,
  output kehr_pkg::cmd_t    cmd_o
);

  localparam int CmpW = 11;

  logic accept;
  logic keep;
  logic in_table;

  // Stall only while the queue has no room
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Key events other than repeats go on
  assign keep = (event_type_i == kehr_pkg::EvTypeKey) &&
                (key_value_i != kehr_pkg::KeyRepeat);

  assign push_o = accept && keep;

  // Translation; codes past the table give usage zero
  assign in_table = ({1'b0, key_code_i} < CmpW'(TABLE_SIZE)) &&
                    ({1'b0, key_code_i} < CmpW'(kehr_pkg::MapEntries));

  always_comb begin
    cmd_o.usage = in_table ? kehr_pkg::CodeToUsage[key_code_i[6:0]] : 8'h00;
    cmd_o.press = (key_value_i == kehr_pkg::KeyPress);
  end

endmodule

### rtl/core/kehr_queue.sv
`timescale 1ns / 1ps

module kehr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  kehr_pkg::cmd_t wdata_i,
  input  logic           pop_i,
  output kehr_pkg::cmd_t rdata_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int Depth = kehr_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  kehr_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### rtl/core/kehr_back.sv
`timescale 1ns / 1ps

module kehr_back #(
  parameter int NUM_SLOTS = kehr_pkg::NumSlotsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  kehr_pkg::cmd_t cmd_i,
  output logic           pop_o,
  input  logic [7:0]     report_id_i,
  input  logic [7:0]     modifier_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output logic [7:0]     report_byte_o,
  output logic [3:0]     byte_index_o,
  output logic           last_byte_o
);

  localparam int LenW = $clog2(kehr_pkg::ReportLen);

  logic [7:0] slots_q [NUM_SLOTS];
  logic [7:0] slots_d [NUM_SLOTS];

  logic            busy_q, busy_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      byte_q, byte_d;
  logic [3:0]      idx_q, idx_d;
  logic            last_q, last_d;

  logic       adv;
  logic       found;
  logic [7:0] match_val;
  logic [7:0] rep_bytes [kehr_pkg::ReportLen];

  // Output register moves on when empty or taken
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !busy_q && !q_empty_i;

  // Slot update: first empty slot on press, first match on release
  always_comb begin
    found     = 1'b0;
    match_val = cmd_i.press ? 8'h00 : cmd_i.usage;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slots_d[i] = slots_q[i];
      if (pop_o && !found && (slots_q[i] == match_val)) begin
        slots_d[i] = cmd_i.press ? cmd_i.usage : 8'h00;
        found      = 1'b1;
      end
    end
  end

  // Report layout
  always_comb begin
    for (int k = 0; k < kehr_pkg::ReportLen; k++) begin
      rep_bytes[k] = 8'h00;
      if (k >= kehr_pkg::HeadBytes) begin
        if ((k - kehr_pkg::HeadBytes < NUM_SLOTS) &&
            (k - kehr_pkg::HeadBytes < kehr_pkg::SlotBytes)) begin
          rep_bytes[k] = slots_q[k - kehr_pkg::HeadBytes];
        end
      end
    end
    rep_bytes[0] = report_id_i;
    rep_bytes[1] = modifier_i;
  end

  // Serialiser: one beat per cycle while the output is not stalled, sixteen beats per report
  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    idx_d       = idx_q;
    last_d      = last_q;
    if (adv) begin
      if (busy_q) begin
        out_valid_d = 1'b1;
        byte_d      = rep_bytes[cnt_q];
        idx_d       = 4'(cnt_q);
        last_d      = (cnt_q == LenW'(kehr_pkg::ReportLen - 1));
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == LenW'(kehr_pkg::ReportLen - 1)) begin
          busy_d = 1'b0;
        end
      end else if (!q_empty_i) begin
        out_valid_d = 1'b1;
        byte_d      = report_id_i;
        idx_d       = 4'd0;
        last_d      = 1'b0;
        cnt_d       = LenW'(1);
        busy_d      = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slots_q[i] <= 8'h00;
      end
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slots_q[i] <= slots_d[i];
      end
    end
  end

  // Beat payload
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    idx_q  <= idx_d;
    last_q <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign report_byte_o = byte_q;
  assign byte_index_o  = idx_q;
  assign last_byte_o   = last_q;

endmodule

### rtl/core/key_event_to_hid_report.sv
`timescale 1ns / 1ps

// Key event to HID keyboard report builder.
// Input channel (in_valid_i / in_stall_o) carries one event beat: type, code
// and value. Non-key events and repeats are swallowed and produce nothing.
// Every other event updates the held-key slots and yields one 16-beat report
// on the output channel (out_valid_o / out_stall_i): report id, modifier
// byte, a zero pad, then slots 0 to 12; last_byte_o marks beat 15.
// The event is written into the command queue and the first beat of its report
// is then registered at the output. Reports leave through the byte-wide
// output serialiser; a two-entry command queue sits between the event front
// end and the serialiser, so events are taken while a report is still going
// out and in_stall_o rises only when the queue is full.
// When the receiver stalls the current beat holds and the serialiser waits;
// the queue then fills and the input side stalls in turn.
// Reset clears all slots, empties the queue and sets report id to 1 and the
// modifier byte to 0. Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) takes
// effect on the next edge and should be written while the block is idle.
module key_event_to_hid_report #(
  parameter int NUM_SLOTS  = kehr_pkg::NumSlotsDefault,
  parameter int TABLE_SIZE = kehr_pkg::TableSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] event_type_i,
  input  logic [9:0]  key_code_i,
  input  logic [1:0]  key_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  report_byte_o,
  output logic [3:0]  byte_index_o,
  output logic        last_byte_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);

  logic [7:0]     report_id_q;
  logic [7:0]     modifier_q;
  logic           push;
  logic           pop;
  logic           q_empty;
  logic           q_full;
  kehr_pkg::cmd_t cmd_in;
  kehr_pkg::cmd_t cmd_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_id_q <= kehr_pkg::ReportIdReset;
      modifier_q  <= kehr_pkg::ModifierReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kehr_pkg::RegReportId: report_id_q <= cfg_wdata_i;
        kehr_pkg::RegModifier: modifier_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  kehr_front #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .q_full_i    (q_full),
    .event_type_i(event_type_i),
    .key_code_i  (key_code_i),
    .key_value_i (key_value_i),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  kehr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(cmd_in),
    .pop_i  (pop),
    .rdata_o(cmd_out),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  kehr_back #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .cmd_i        (cmd_out),
    .pop_o        (pop),
    .report_id_i  (report_id_q),
    .modifier_i   (modifier_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .report_byte_o(report_byte_o),
    .byte_index_o (byte_index_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

  // Key value outside the defined set, handled as a release
  localparam logic [1:0] KeyValueOdd = 2'd3;
  localparam int MaxWait      = 8;
  localparam int SettleCycles = 40;
  localparam int MaxShown     = 10;
  localparam int RandomEvents = 390;

  // Key code to HID usage, kept independently of the design
  localparam logic [7:0] UsageMap [128] = '{
    8'h00, 8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25,
    8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A, 8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15,
    8'h17, 8'h1C, 8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h28, 8'hE0,
    8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33,
    8'h34, 8'h35, 8'hE1, 8'h32, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11,
    8'h10, 8'h36, 8'h37, 8'h38, 8'hE5, 8'h55, 8'hE2, 8'h2C, 8'h39, 8'h3A,
    8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h53,
    8'h47, 8'h5F, 8'h60, 8'h61, 8'h56, 8'h5C, 8'h5D, 8'h5E, 8'h57, 8'h59,
    8'h5A, 8'h5B, 8'h62, 8'h63, 8'h00, 8'h00, 8'h00, 8'h44, 8'h45, 8'h87,
    8'h6A, 8'h00, 8'h8A, 8'h88, 8'h8B, 8'h00, 8'h58, 8'hE4, 8'h54, 8'h46,
    8'hE6, 8'h00, 8'h4A, 8'h52, 8'h4B, 8'h5C, 8'h4F, 8'h4D, 8'h51, 8'h4E,
    8'h49, 8'h4C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h89, 8'hE3, 8'hE7, 8'h65
  };

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] idx;
    logic       last;
  } hid_beat_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        ev_valid  = 1'b0;
  logic        ev_stall;
  logic [15:0] ev_type   = '0;
  logic [9:0]  ev_code   = '0;
  logic [1:0]  ev_value  = '0;
  logic        rep_valid;
  logic        rep_stall = 1'b0;
  logic [7:0]  rep_byte;
  logic [3:0]  rep_idx;
  logic        rep_last;
  logic        cfg_we    = 1'b0;
  logic        cfg_idx   = kehr_pkg::RegReportId;
  logic [7:0]  cfg_wdata = '0;

  // Predicted state of the block
  logic [7:0] held_usage [kehr_pkg::NumSlotsDefault] = '{default: 8'h00};
  logic [7:0] cur_report_id = kehr_pkg::ReportIdReset;
  logic [7:0] cur_modifier  = kehr_pkg::ModifierReset;
  hid_beat_t  pending_beats [$];
  int         mismatches    = 0;
  int         hold_left     = 0;
  bit         tx_idle_en    = 1'b1;
  bit         rx_idle_en    = 1'b1;

  key_event_to_hid_report dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (ev_valid),
    .in_stall_o   (ev_stall),
    .event_type_i (ev_type),
    .key_code_i   (ev_code),
    .key_value_i  (ev_value),
    .out_valid_o  (rep_valid),
    .out_stall_i  (rep_stall),
    .report_byte_o(rep_byte),
    .byte_index_o (rep_idx),
    .last_byte_o  (rep_last),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Update held keys for one event and queue the report it produces
  function automatic void predict_report(logic [15:0] etype, logic [9:0] code,
                                         logic [1:0] kval);
    logic [7:0] usage;
    hid_beat_t  b;
    bit         done;
    int         k;
    if (etype != kehr_pkg::EvTypeKey || kval == kehr_pkg::KeyRepeat) return;
    usage = (code < kehr_pkg::TableSizeDefault) ? UsageMap[code[6:0]] : 8'h00;
    done = 1'b0;
    for (k = 0; k < kehr_pkg::NumSlotsDefault; k++) begin
      if (!done && kval == kehr_pkg::KeyPress && held_usage[k] == 8'h00) begin
        held_usage[k] = usage;
        done = 1'b1;
      end else if (!done && kval != kehr_pkg::KeyPress && held_usage[k] == usage) begin
        held_usage[k] = 8'h00;
        done = 1'b1;
      end
    end
    for (k = 0; k < kehr_pkg::ReportLen; k++) begin
      if (k == 0) begin
        b.data = cur_report_id;
      end else if (k == 1) begin
        b.data = cur_modifier;
      end else if (k >= kehr_pkg::HeadBytes &&
                   k - kehr_pkg::HeadBytes < kehr_pkg::SlotBytes &&
                   k - kehr_pkg::HeadBytes < kehr_pkg::NumSlotsDefault) begin
        b.data = held_usage[k - kehr_pkg::HeadBytes];
      end else begin
        b.data = 8'h00;
      end
      b.idx  = k[3:0];
      b.last = (k == kehr_pkg::ReportLen - 1);
      pending_beats.push_back(b);
    end
  endfunction

  // Compare one accepted report beat with the oldest expectation
  function automatic void check_beat();
    hid_beat_t want;
    if (pending_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxShown)
        $display("%0t: unexpected beat: byte %02h index %0d last %0b",
                 $time, rep_byte, rep_idx, rep_last);
      return;
    end
    want = pending_beats.pop_front();
    if (rep_byte !== want.data || rep_idx !== want.idx || rep_last !== want.last) begin
      mismatches++;
      if (mismatches <= MaxShown)
        $display("%0t: expected byte %02h index %0d last %0b, got byte %02h index %0d last %0b",
                 $time, want.data, want.idx, want.last, rep_byte, rep_idx, rep_last);
    end
  endfunction

  // Report receiver with random stalls after each beat
  always @(posedge clk) begin
    int n;
    if (rep_valid && !rep_stall) begin
      check_beat();
      n = rx_idle_en ? $urandom_range(0, MaxWait) : 0;
      hold_left = n;
      rep_stall <= (n != 0);
    end else if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) rep_stall <= 1'b0;
    end
  end

  // Send one event beat after a random gap; called and returns on a rising edge
  task automatic send_event(input logic [15:0] etype, input logic [9:0] code,
                            input logic [1:0] kval);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, MaxWait) : 0;
    if (gap > 0) begin
      ev_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_valid <= 1'b1;
    ev_type  <= etype;
    ev_code  <= code;
    ev_value <= kval;
    do @(posedge clk); while (ev_stall);
    predict_report(etype, code, kval);
  endtask

  // Stop sending and let every expected report drain out
  task automatic wait_reports_done();
    ev_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == kehr_pkg::RegReportId) cur_report_id = value;
    else cur_modifier = value;
  endtask

  // Field extremes, dropped events, odd key value, duplicates and unknown codes
  task automatic test_special_cases();
    send_event(kehr_pkg::EvTypeKey, 10'd30, kehr_pkg::KeyPress);
    send_event(kehr_pkg::EvTypeKey, 10'd30, kehr_pkg::KeyPress);
    send_event(kehr_pkg::EvTypeKey, 10'd30, kehr_pkg::KeyRelease);
    send_event(kehr_pkg::EvTypeKey, 10'd30, kehr_pkg::KeyRelease);
    send_event(kehr_pkg::EvTypeKey, 10'd30, kehr_pkg::KeyRelease);
    send_event(kehr_pkg::EvTypeKey, 10'd0, kehr_pkg::KeyPress);
    send_event(kehr_pkg::EvTypeKey, 10'd0, kehr_pkg::KeyRelease);
    send_event(kehr_pkg::EvTypeKey, 10'd128, kehr_pkg::KeyPress);
    send_event(kehr_pkg::EvTypeKey, 10'd767, kehr_pkg::KeyPress);
    send_event(kehr_pkg::EvTypeKey, 10'd512, kehr_pkg::KeyRelease);
    send_event(kehr_pkg::EvTypeKey, 10'd256, kehr_pkg::KeyPress);
    send_event(kehr_pkg::EvTypeKey, 10'd2, kehr_pkg::KeyPress);
    send_event(kehr_pkg::EvTypeKey, 10'd2, KeyValueOdd);
    send_event(kehr_pkg::EvTypeKey, 10'd5, kehr_pkg::KeyRepeat);
    send_event(16'h0000, 10'd5, kehr_pkg::KeyPress);
    send_event(16'hFFFF, 10'd5, kehr_pkg::KeyPress);
    send_event(16'h0101, 10'd5, kehr_pkg::KeyPress);
    send_event(kehr_pkg::EvTypeKey, 10'd126, kehr_pkg::KeyPress);
    send_event(kehr_pkg::EvTypeKey, 10'd127, kehr_pkg::KeyPress);
    send_event(kehr_pkg::EvTypeKey, 10'd126, kehr_pkg::KeyRelease);
    send_event(kehr_pkg::EvTypeKey, 10'd84, kehr_pkg::KeyPress);
    send_event(kehr_pkg::EvTypeKey, 10'd99, kehr_pkg::KeyRelease);
  endtask

  // Fill every slot, press two more keys while full, then free them again
  task automatic test_full_slots();
    int c;
    for (c = 1; c <= kehr_pkg::NumSlotsDefault + 2; c++)
      send_event(kehr_pkg::EvTypeKey, c[9:0], kehr_pkg::KeyPress);
    send_event(kehr_pkg::EvTypeKey, 10'd1, kehr_pkg::KeyRelease);
    send_event(kehr_pkg::EvTypeKey, 10'd40, kehr_pkg::KeyPress);
    for (c = kehr_pkg::NumSlotsDefault + 2; c >= 1; c--)
      send_event(kehr_pkg::EvTypeKey, c[9:0], kehr_pkg::KeyRelease);
    send_event(kehr_pkg::EvTypeKey, 10'd40, kehr_pkg::KeyRelease);
    send_event(kehr_pkg::EvTypeKey, 10'd127, kehr_pkg::KeyRelease);
  endtask

  // Header bytes at their extremes and a mid pattern
  task automatic test_config_extremes();
    wait_reports_done();
    write_reg(kehr_pkg::RegReportId, 8'h00);
    write_reg(kehr_pkg::RegModifier, 8'hFF);
    send_event(kehr_pkg::EvTypeKey, 10'd44, kehr_pkg::KeyPress);
    send_event(kehr_pkg::EvTypeKey, 10'd44, kehr_pkg::KeyRelease);
    wait_reports_done();
    write_reg(kehr_pkg::RegReportId, 8'hFF);
    write_reg(kehr_pkg::RegModifier, 8'h00);
    send_event(kehr_pkg::EvTypeKey, 10'd57, kehr_pkg::KeyPress);
    send_event(kehr_pkg::EvTypeKey, 10'd57, kehr_pkg::KeyRelease);
    wait_reports_done();
    write_reg(kehr_pkg::RegReportId, 8'hA5);
    write_reg(kehr_pkg::RegModifier, 8'h5A);
    send_event(kehr_pkg::EvTypeKey, 10'd16, kehr_pkg::KeyPress);
  endtask

  // Mostly key traffic over a small key set, with some noise events
  task automatic send_random_event();
    logic [15:0] etype;
    logic [9:0]  code;
    logic [1:0]  kval;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      etype = 16'($urandom_range(0, 16'hFFFF));
      code  = 10'($urandom_range(0, 767));
      kval  = 2'($urandom_range(0, 3));
    end else begin
      etype = kehr_pkg::EvTypeKey;
      pick = $urandom_range(0, 99);
      if (pick < 60) code = 10'($urandom_range(1, 16));
      else if (pick < 90) code = 10'($urandom_range(0, 127));
      else code = 10'($urandom_range(128, 767));
      pick = $urandom_range(0, 99);
      if (pick < 45) kval = kehr_pkg::KeyPress;
      else if (pick < 90) kval = kehr_pkg::KeyRelease;
      else if (pick < 95) kval = kehr_pkg::KeyRepeat;
      else kval = KeyValueOdd;
    end
    send_event(etype, code, kval);
  endtask

  // Random phases: idling on or off per side, drain and new header values
  task automatic test_random_traffic();
    int n;
    for (n = 0; n < RandomEvents; n++) begin
      if (n % 45 == 0) begin
        if (n % 135 == 0) begin
          wait_reports_done();
          write_reg(kehr_pkg::RegReportId, 8'($urandom_range(0, 255)));
          write_reg(kehr_pkg::RegModifier, 8'($urandom_range(0, 255)));
        end
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      send_random_event();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_full_slots();
    test_config_extremes();
    test_random_traffic();
    wait_reports_done();
    if (mismatches == 0) begin
      $display("PASS key_event_to_hid_report");
    end else begin
      $display("FAIL key_event_to_hid_report");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("FAIL key_event_to_hid_report");
    $finish;
  end

endmodule
